>>> hdl/wssb_pkg.sv
package wssb_pkg;

  // Fixed field widths
  localparam int COORD_W = 32;
  localparam int CH_W    = 16;
  localparam int ADDR_W  = 16;
  localparam int CFG_W   = 9;
  localparam int TEXEL_W = 3 * CH_W;

  // Grid limits and weight precision
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 16;
  localparam int WGT_W      = FRAC_BITS + 1;
  localparam logic [WGT_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Wrapped cell widths (cell index < size-1)
  localparam int MY_W = $clog2(MAX_WIDTH);
  localparam int MZ_W = $clog2(MAX_HEIGHT);

  // Integer part of a Q16.16 coordinate after scale and shift
  localparam int INT_W       = 33;
  localparam int WRAP_STEPS  = 4;
  localparam int WRAP_STAGES = (INT_W + WRAP_STEPS - 1) / WRAP_STEPS;
  localparam int WRAP_BITS   = WRAP_STAGES * WRAP_STEPS;

  // Banked store: two copies, each split by address parity
  localparam int RAM_DEPTH = 2 ** (ADDR_W - 1);
  localparam int RAM_AW    = ADDR_W - 1;

  // Configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam logic [2:0] REG_SCALE_Y = 3'd0;
  localparam logic [2:0] REG_SCALE_Z = 3'd1;
  localparam logic [2:0] REG_SHIFT_Y = 3'd2;
  localparam logic [2:0] REG_SHIFT_Z = 3'd3;
  localparam logic [2:0] REG_WIDTH   = 3'd4;
  localparam logic [2:0] REG_HEIGHT  = 3'd5;

  // Operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic                      operation;
    logic [ADDR_W-1:0]         texel_index;
    logic [CH_W-1:0]           texel_red;
    logic [CH_W-1:0]           texel_green;
    logic [CH_W-1:0]           texel_blue;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } wssb_in_t;

  typedef struct packed {
    logic [CH_W-1:0] color_red;
    logic [CH_W-1:0] color_green;
    logic [CH_W-1:0] color_blue;
  } wssb_out_t;

  // Write part of an item, carried down the pipe
  typedef struct packed {
    logic               operation;
    logic [ADDR_W-1:0]  texel_index;
    logic [TEXEL_W-1:0] texel;
  } wssb_wr_t;

  typedef struct packed {
    wssb_wr_t         wr;
    logic [WGT_W-1:0] wgt_y;
    logic [WGT_W-1:0] wgt_z;
    logic [MY_W:0]    width;
  } wssb_side_t;

  typedef struct packed {
    logic [INT_W-1:0] mag_y;
    logic             neg_y;
    logic [MY_W-1:0]  m_y;
    logic [INT_W-1:0] mag_z;
    logic             neg_z;
    logic [MZ_W-1:0]  m_z;
    wssb_side_t       side;
  } wssb_wrap_in_t;

  typedef struct packed {
    logic [MY_W-1:0] cell_y;
    logic [MZ_W-1:0] cell_z;
    wssb_side_t      side;
  } wssb_wrap_out_t;

  // Linear blend p*(1-w1) + q*w1, low bits dropped, saturated to a channel
  function automatic logic [CH_W-1:0] lerp(input logic [CH_W-1:0] p,
                                           input logic [CH_W-1:0] q,
                                           input logic [WGT_W-1:0] w1);
    logic [WGT_W-1:0]                  w0;
    logic [CH_W+WGT_W:0]               acc;
    logic [CH_W+WGT_W-FRAC_BITS:0]     r;
    w0  = ONE - w1;
    acc = p * w0 + q * w1;
    r   = acc[CH_W+WGT_W:FRAC_BITS];
    if (|r[CH_W+WGT_W-FRAC_BITS:CH_W]) begin
      return '1;
    end
    return r[CH_W-1:0];
  endfunction

endpackage

>>> hdl/wssb_ram.sv
module wssb_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/wssb_wrap.sv
module wssb_wrap (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  wssb_pkg::wssb_wrap_in_t in_i,
  output logic                    out_valid_o,
  output wssb_pkg::wssb_wrap_out_t out_o
);
  import wssb_pkg::*;

  localparam int RW = (MY_W > MZ_W) ? MY_W : MZ_W;

  typedef struct packed {
    wssb_wrap_in_t d;
    logic [RW-1:0] rem_y;
    logic [RW-1:0] rem_z;
  } stage_t;

  stage_t                 st_q [WRAP_STAGES];
  logic [WRAP_STAGES-1:0] v_q;
  wssb_wrap_out_t         out_q;
  logic                   ov_q;

  // Restoring remainder, a few magnitude bits per stage
  function automatic logic [RW-1:0] mod_steps(input logic [RW-1:0] rem,
                                              input logic [WRAP_STEPS-1:0] bits,
                                              input logic [RW-1:0] m);
    logic [RW:0]   x;
    logic [RW-1:0] r;
    r = rem;
    for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
      x = {r, bits[k]};
      if (x >= {1'b0, m}) begin
        x = x - {1'b0, m};
      end
      r = x[RW-1:0];
    end
    return r;
  endfunction

  for (genvar s = 0; s < WRAP_STAGES; s++) begin : g_stage
    stage_t                 prev;
    logic                   prev_v;
    logic [WRAP_BITS-1:0]   ext_y;
    logic [WRAP_BITS-1:0]   ext_z;
    stage_t                 st_d;

    if (s == 0) begin : g_first
      assign prev   = '{d: in_i, rem_y: '0, rem_z: '0};
      assign prev_v = in_valid_i;
    end else begin : g_next
      assign prev   = st_q[s-1];
      assign prev_v = v_q[s-1];
    end

    assign ext_y = WRAP_BITS'(prev.d.mag_y);
    assign ext_z = WRAP_BITS'(prev.d.mag_z);

    always_comb begin
      st_d       = prev;
      st_d.rem_y = mod_steps(prev.rem_y, ext_y[WRAP_BITS-1-s*WRAP_STEPS -: WRAP_STEPS],
                             RW'(prev.d.m_y));
      st_d.rem_z = mod_steps(prev.rem_z, ext_z[WRAP_BITS-1-s*WRAP_STEPS -: WRAP_STEPS],
                             RW'(prev.d.m_z));
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[s] <= st_d;
    end
  end

  // Make the remainder non-negative for negative integer parts
  stage_t         last;
  logic [RW-1:0]  cy;
  logic [RW-1:0]  cz;
  wssb_wrap_out_t out_d;

  assign last = st_q[WRAP_STAGES-1];

  always_comb begin
    cy = last.rem_y;
    cz = last.rem_z;
    if (last.d.neg_y && (last.rem_y != '0)) begin
      cy = RW'(last.d.m_y) - last.rem_y;
    end
    if (last.d.neg_z && (last.rem_z != '0)) begin
      cz = RW'(last.d.m_z) - last.rem_z;
    end
    out_d.cell_y = cy[MY_W-1:0];
    out_d.cell_z = cz[MZ_W-1:0];
    out_d.side   = last.d.side;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= v_q[WRAP_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = ov_q;
  assign out_o       = out_q;

endmodule

>>> hdl/wrapped_smoothstep_bilinear_sampler_core.sv
// Channel   | Direction | Handshake                  | Word
// ----------+-----------+----------------------------+---------------------------
// item      | in        | start high, busy low       | wssb_in_t (write or sample)
// result    | out       | result_valid_o one cycle   | wssb_out_t (three channels)
// config    | in/out    | APB, pready always high    | 32-bit registers at 4*i
//
// A new word is taken every cycle; busy stays low. A sample gives its result
// after 5 map and smoothstep stages, the 10-stage wrap remainder pipeline,
// the address stage, the banked store read and two blend stages. A write
// updates the store at the read stage, in order with samples. Reset clears
// the valid bits and restores the config defaults; the store is not cleared.
// The receiver cannot stall, so nothing is ever held back.
module wrapped_smoothstep_bilinear_sampler_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  wssb_pkg::wssb_in_t            item_i,
  output logic                          result_valid_o,
  output wssb_pkg::wssb_out_t           result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wssb_pkg::CFG_AW-1:0]   paddr,
  input  logic [wssb_pkg::CFG_DW-1:0]   pwdata,
  output logic [wssb_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import wssb_pkg::*;

  localparam int LATENCY = 5 + WRAP_STAGES + 1 + 4;
  localparam logic [FRAC_BITS+1:0] THREE = {2'b11, {FRAC_BITS{1'b0}}};

  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign pready = 1'b1;

  // Configuration registers
  logic signed [COORD_W-1:0] scale_y_q, scale_z_q, shift_y_q, shift_z_q;
  logic [CFG_W-1:0]          width_q, height_q;
  logic                      cfg_we;
  logic [2:0]                cfg_idx;

  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[CFG_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_y_q <= 32'sd65536;
      scale_z_q <= 32'sd65536;
      shift_y_q <= '0;
      shift_z_q <= '0;
      width_q   <= CFG_W'(MAX_WIDTH);
      height_q  <= CFG_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SCALE_Y: scale_y_q <= pwdata;
        REG_SCALE_Z: scale_z_q <= pwdata;
        REG_SHIFT_Y: shift_y_q <= pwdata;
        REG_SHIFT_Z: shift_z_q <= pwdata;
        REG_WIDTH:   width_q   <= pwdata[CFG_W-1:0];
        REG_HEIGHT:  height_q  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SCALE_Y: prdata = scale_y_q;
      REG_SCALE_Z: prdata = scale_z_q;
      REG_SHIFT_Y: prdata = shift_y_q;
      REG_SHIFT_Z: prdata = shift_z_q;
      REG_WIDTH:   prdata = CFG_DW'(width_q);
      REG_HEIGHT:  prdata = CFG_DW'(height_q);
      default:     prdata = '0;
    endcase
  end

  // Grid sizes used clamped to 2..MAX
  function automatic logic [MY_W:0] clamp_w(input logic [CFG_W-1:0] v);
    if (v < CFG_W'(2)) return (MY_W+1)'(2);
    if (int'(v) > MAX_WIDTH) return (MY_W+1)'(MAX_WIDTH);
    return (MY_W+1)'(v);
  endfunction

  function automatic logic [MZ_W:0] clamp_h(input logic [CFG_W-1:0] v);
    if (v < CFG_W'(2)) return (MZ_W+1)'(2);
    if (int'(v) > MAX_HEIGHT) return (MZ_W+1)'(MAX_HEIGHT);
    return (MZ_W+1)'(v);
  endfunction

  // Stage 1: input register
  wssb_in_t in_q;
  logic     v1_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= item_i;
    end
  end

  // Stage 2: coordinate times scale
  logic signed [2*COORD_W-1:0] prod_y_q, prod_z_q;
  wssb_wr_t                    wr2_q;
  logic                        v2_q;

  always_ff @(posedge clk_i) begin
    prod_y_q <= in_q.coord_y * scale_y_q;
    prod_z_q <= in_q.coord_z * scale_z_q;
    wr2_q    <= '{operation: in_q.operation, texel_index: in_q.texel_index,
                  texel: {in_q.texel_red, in_q.texel_green, in_q.texel_blue}};
  end

  // Stage 3: drop low bits and add the offset
  logic signed [48:0] t_y_q, t_z_q;
  wssb_wr_t           wr3_q;
  logic               v3_q;

  always_ff @(posedge clk_i) begin
    t_y_q <= 49'(prod_y_q >>> 16) + 49'(shift_y_q);
    t_z_q <= 49'(prod_z_q >>> 16) + 49'(shift_z_q);
    wr3_q <= wr2_q;
  end

  // Stage 4: integer magnitude and sign, fraction squared, sizes
  logic [INT_W-1:0]       i_y, i_z;
  logic [15+FRAC_BITS:0]  fx_y, fx_z;
  logic [FRAC_BITS-1:0]   f_y, f_z;
  logic [MY_W:0]          wc;
  logic [MZ_W:0]          hc;

  assign i_y  = t_y_q[48:16];
  assign i_z  = t_z_q[48:16];
  assign fx_y = {t_y_q[15:0], {FRAC_BITS{1'b0}}} >> 16;
  assign fx_z = {t_z_q[15:0], {FRAC_BITS{1'b0}}} >> 16;
  assign f_y  = fx_y[FRAC_BITS-1:0];
  assign f_z  = fx_z[FRAC_BITS-1:0];
  assign wc   = clamp_w(width_q);
  assign hc   = clamp_h(height_q);

  logic [INT_W-1:0]       mag_y_q, mag_z_q;
  logic                   neg_y_q, neg_z_q;
  logic [FRAC_BITS-1:0]   f_y_q, f_z_q;
  logic [2*FRAC_BITS-1:0] f2_y_q, f2_z_q;
  logic [MY_W-1:0]        m_y_q;
  logic [MZ_W-1:0]        m_z_q;
  logic [MY_W:0]          wid_q;
  wssb_wr_t               wr4_q;
  logic                   v4_q;

  always_ff @(posedge clk_i) begin
    neg_y_q <= i_y[INT_W-1];
    neg_z_q <= i_z[INT_W-1];
    mag_y_q <= i_y[INT_W-1] ? (~i_y + INT_W'(1)) : i_y;
    mag_z_q <= i_z[INT_W-1] ? (~i_z + INT_W'(1)) : i_z;
    f_y_q   <= f_y;
    f_z_q   <= f_z;
    f2_y_q  <= f_y * f_y;
    f2_z_q  <= f_z * f_z;
    m_y_q   <= MY_W'(wc - (MY_W+1)'(1));
    m_z_q   <= MZ_W'(hc - (MZ_W+1)'(1));
    wid_q   <= wc;
    wr4_q   <= wr3_q;
  end

  // Stage 5: smoothstep weight a*(3 - 2f)
  logic [2*FRAC_BITS+1:0] sp_y, sp_z;
  wssb_wrap_in_t          wrap_in_q;
  logic                   v5_q;

  assign sp_y = f2_y_q[2*FRAC_BITS-1:FRAC_BITS] * (THREE - {1'b0, f_y_q, 1'b0});
  assign sp_z = f2_z_q[2*FRAC_BITS-1:FRAC_BITS] * (THREE - {1'b0, f_z_q, 1'b0});

  always_ff @(posedge clk_i) begin
    wrap_in_q.mag_y      <= mag_y_q;
    wrap_in_q.neg_y      <= neg_y_q;
    wrap_in_q.m_y        <= m_y_q;
    wrap_in_q.mag_z      <= mag_z_q;
    wrap_in_q.neg_z      <= neg_z_q;
    wrap_in_q.m_z        <= m_z_q;
    wrap_in_q.side.wr    <= wr4_q;
    wrap_in_q.side.wgt_y <= sp_y[FRAC_BITS +: WGT_W];
    wrap_in_q.side.wgt_z <= sp_z[FRAC_BITS +: WGT_W];
    wrap_in_q.side.width <= wid_q;
  end

  // Wrap into 0..size-2
  logic           wv;
  wssb_wrap_out_t wo;

  wssb_wrap u_wrap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v5_q),
    .in_i        (wrap_in_q),
    .out_valid_o (wv),
    .out_o       (wo)
  );

  // Address stage: base = y + z*width
  logic [MZ_W+MY_W:0] row_off;
  logic [ADDR_W-1:0]  base_q;
  logic [MY_W:0]      wa_q;
  wssb_wr_t           wra_q;
  logic [WGT_W-1:0]   wya_q, wza_q;
  logic               va_q;

  assign row_off = wo.cell_z * wo.side.width;

  always_ff @(posedge clk_i) begin
    base_q <= ADDR_W'(wo.cell_y) + ADDR_W'(row_off);
    wa_q   <= wo.side.width;
    wra_q  <= wo.side.wr;
    wya_q  <= wo.side.wgt_y;
    wza_q  <= wo.side.wgt_z;
  end

  // Store access: top copy serves a0/a1, bottom copy a2/a3
  logic [ADDR_W-1:0] a0, a1, a2, a3;
  logic              is_wr, is_rd;
  logic              we_even, we_odd;
  logic [RAM_AW-1:0] waddr;
  logic [RAM_AW-1:0] top_even_ra, top_odd_ra, bot_even_ra, bot_odd_ra;
  logic [TEXEL_W-1:0] top_even_rd, top_odd_rd, bot_even_rd, bot_odd_rd;

  assign a0 = base_q;
  assign a1 = base_q + ADDR_W'(1);
  assign a2 = base_q + ADDR_W'(wa_q);
  assign a3 = a2 + ADDR_W'(1);

  assign is_wr   = va_q & (wra_q.operation == OP_WRITE);
  assign is_rd   = va_q & (wra_q.operation == OP_SAMPLE);
  assign we_even = is_wr & ~wra_q.texel_index[0];
  assign we_odd  = is_wr & wra_q.texel_index[0];
  assign waddr   = wra_q.texel_index[ADDR_W-1:1];

  assign top_even_ra = a0[0] ? a1[ADDR_W-1:1] : a0[ADDR_W-1:1];
  assign top_odd_ra  = a0[0] ? a0[ADDR_W-1:1] : a1[ADDR_W-1:1];
  assign bot_even_ra = a2[0] ? a3[ADDR_W-1:1] : a2[ADDR_W-1:1];
  assign bot_odd_ra  = a2[0] ? a2[ADDR_W-1:1] : a3[ADDR_W-1:1];

  wssb_ram #(.WIDTH(TEXEL_W), .DEPTH(RAM_DEPTH)) u_top_even (
    .clk_i (clk_i), .we_i (we_even), .waddr_i (waddr), .wdata_i (wra_q.texel),
    .raddr_i (top_even_ra), .rdata_o (top_even_rd)
  );
  wssb_ram #(.WIDTH(TEXEL_W), .DEPTH(RAM_DEPTH)) u_top_odd (
    .clk_i (clk_i), .we_i (we_odd), .waddr_i (waddr), .wdata_i (wra_q.texel),
    .raddr_i (top_odd_ra), .rdata_o (top_odd_rd)
  );
  wssb_ram #(.WIDTH(TEXEL_W), .DEPTH(RAM_DEPTH)) u_bot_even (
    .clk_i (clk_i), .we_i (we_even), .waddr_i (waddr), .wdata_i (wra_q.texel),
    .raddr_i (bot_even_ra), .rdata_o (bot_even_rd)
  );
  wssb_ram #(.WIDTH(TEXEL_W), .DEPTH(RAM_DEPTH)) u_bot_odd (
    .clk_i (clk_i), .we_i (we_odd), .waddr_i (waddr), .wdata_i (wra_q.texel),
    .raddr_i (bot_odd_ra), .rdata_o (bot_odd_rd)
  );

  // Read stage: bank selects travel with the read data
  logic             sel_top_q, sel_bot_q;
  logic [WGT_W-1:0] wyb_q, wzb_q;
  logic             vb_q;

  always_ff @(posedge clk_i) begin
    sel_top_q <= a0[0];
    sel_bot_q <= a2[0];
    wyb_q     <= wya_q;
    wzb_q     <= wza_q;
  end

  logic [TEXEL_W-1:0] t00, t01, t10, t11;

  assign t00 = sel_top_q ? top_odd_rd  : top_even_rd;
  assign t01 = sel_top_q ? top_even_rd : top_odd_rd;
  assign t10 = sel_bot_q ? bot_odd_rd  : bot_even_rd;
  assign t11 = sel_bot_q ? bot_even_rd : bot_odd_rd;

  // Horizontal blend per channel
  logic [CH_W-1:0]  top_q [3];
  logic [CH_W-1:0]  bot_q [3];
  logic [WGT_W-1:0] wzc_q;
  logic             vc_q;

  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 3; ch++) begin
      top_q[ch] <= lerp(t00[TEXEL_W-1-ch*CH_W -: CH_W], t01[TEXEL_W-1-ch*CH_W -: CH_W], wyb_q);
      bot_q[ch] <= lerp(t10[TEXEL_W-1-ch*CH_W -: CH_W], t11[TEXEL_W-1-ch*CH_W -: CH_W], wyb_q);
    end
    wzc_q <= wzb_q;
  end

  // Vertical blend into the result register
  wssb_out_t res_q;
  logic      rv_q;

  always_ff @(posedge clk_i) begin
    res_q.color_red   <= lerp(top_q[0], bot_q[0], wzc_q);
    res_q.color_green <= lerp(top_q[1], bot_q[1], wzc_q);
    res_q.color_blue  <= lerp(top_q[2], bot_q[2], wzc_q);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      rv_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      va_q <= wv;
      vb_q <= is_rd;
      vc_q <= vb_q;
      rv_q <= vc_q;
    end
  end

  assign result_valid_o = rv_q;
  assign result_o       = res_q;

`ifndef SYNTHESIS
  // Every sample, and only a sample, gives a result after the fixed latency
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o == $past(accept && rst_ni && (item_i.operation == OP_SAMPLE), LATENCY))
    else $error("result strobe does not match accepted samples");

  // A store write and a store read never share the access stage
  a_port_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(is_wr && is_rd))
    else $error("store write and read in the same cycle");

  // Read data is consumed only in the cycle after a read was issued
  a_read_follow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q |-> $past(is_rd))
    else $error("blend stage valid without a store read");
`endif

endmodule

>>> test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wssb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int STORE_FILL = 512;

  // Bit-exact model of the sampler plus the queue of pending colors
  class color_board;
    logic [TEXEL_W-1:0] texels [int];
    logic [31:0] scl_y, scl_z, sft_y, sft_z;
    logic [8:0] wid, hgt;
    wssb_out_t pending [$];
    int errors;
    int samples;

    function new();
      scl_y = 32'h10000; scl_z = 32'h10000; sft_y = 0; sft_z = 0;
      wid = 9'd256; hgt = 9'd256; errors = 0; samples = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_SCALE_Y: scl_y = val;
        REG_SCALE_Z: scl_z = val;
        REG_SHIFT_Y: sft_y = val;
        REG_SHIFT_Z: sft_z = val;
        REG_WIDTH:   wid = val[8:0];
        REG_HEIGHT:  hgt = val[8:0];
        default: ;
      endcase
    endfunction

    // wrapped cell and smoothstep weight of one coordinate
    function void map_axis(logic [31:0] c, logic [31:0] sc, logic [31:0] sh,
                           longint size, output longint cell_idx, output longint wgt);
      longint prod, t, i, m, f, a;
      prod = longint'($signed(c)) * longint'($signed(sc));
      t = (prod >>> 16) + longint'($signed(sh));
      i = t >>> 16;
      m = size - 1;
      i = i % m;
      if (i < 0) i += m;
      cell_idx = i;
      f = t & 64'hFFFF;
      a = (f * f) >> 16;
      wgt = (a * (3 * 65536 - 2 * f)) >> 16;
    endfunction

    function longint mix(longint p, longint q, longint w1);
      return (p * (65536 - w1) + q * w1) >> 16;
    endfunction

    function logic [TEXEL_W-1:0] peek(longint a);
      int k;
      k = int'(a & 64'hFFFF);
      return texels.exists(k) ? texels[k] : '0;
    endfunction

    function void note_item(wssb_in_t it);
      longint w, h, cy, cz, wy, wz, base, top, bot, r;
      logic [TEXEL_W-1:0] t00, t01, t10, t11;
      wssb_out_t o;
      if (it.operation == OP_WRITE) begin
        texels[int'(it.texel_index)] = {it.texel_red, it.texel_green, it.texel_blue};
        return;
      end
      w = (wid < 2) ? 2 : (wid > MAX_WIDTH) ? MAX_WIDTH : wid;
      h = (hgt < 2) ? 2 : (hgt > MAX_HEIGHT) ? MAX_HEIGHT : hgt;
      map_axis(it.coord_y, scl_y, sft_y, w, cy, wy);
      map_axis(it.coord_z, scl_z, sft_z, h, cz, wz);
      base = cy + cz * w;
      t00 = peek(base); t01 = peek(base + 1);
      t10 = peek(base + w); t11 = peek(base + w + 1);
      for (int ch = 0; ch < 3; ch++) begin
        top = mix(t00[47-16*ch -: 16], t01[47-16*ch -: 16], wy);
        bot = mix(t10[47-16*ch -: 16], t11[47-16*ch -: 16], wy);
        r = mix(top, bot, wz);
        if (r > 65535) r = 65535;
        case (ch)
          0: o.color_red = r[15:0];
          1: o.color_green = r[15:0];
          default: o.color_blue = r[15:0];
        endcase
      end
      pending.push_back(o);
      samples++;
    endfunction

    function void check_color(wssb_out_t got);
      wssb_out_t exp_c;
      if (pending.size() == 0) begin
        $error("color word with nothing pending");
        errors++;
        return;
      end
      exp_c = pending.pop_front();
      if (got.color_red !== exp_c.color_red) begin
        $error("color_red exp %h got %h", exp_c.color_red, got.color_red); errors++;
      end
      if (got.color_green !== exp_c.color_green) begin
        $error("color_green exp %h got %h", exp_c.color_green, got.color_green); errors++;
      end
      if (got.color_blue !== exp_c.color_blue) begin
        $error("color_blue exp %h got %h", exp_c.color_blue, got.color_blue); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start = 0;
  logic busy;
  wssb_in_t item_i = '0;
  logic result_valid_o;
  wssb_out_t result_o;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  color_board board = new();
  int cycles = 0;
  int idle_pct = 0;

  wrapped_smoothstep_bilinear_sampler_core DUT (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("wrapped_smoothstep_bilinear_sampler_core test failed");
      $finish;
    end
  end

  // results are taken at the edge that ends their cycle
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) board.check_color(result_o);
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= CFG_AW'(idx) << 2; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.set_reg(idx, val);
  endtask

  // one word in, with a random idle gap before it
  task automatic send_word(wssb_in_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk_i);
    end
    start <= 1; item_i <= it;
    do @(posedge clk_i); while (busy);
    board.note_item(it);
  endtask

  // drop start right after the last accepted word, then drain
  task automatic settle();
    start <= 0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic wssb_in_t load_word(logic [15:0] idx, logic [47:0] t);
    wssb_in_t it;
    it = '0;
    it.operation = OP_WRITE;
    it.texel_index = idx;
    {it.texel_red, it.texel_green, it.texel_blue} = t;
    it.coord_y = $urandom; it.coord_z = $urandom;
    return it;
  endfunction

  function automatic wssb_in_t sample_word(logic [31:0] y, logic [31:0] z);
    wssb_in_t it;
    it = '0;
    it.operation = OP_SAMPLE;
    it.texel_index = 16'($urandom);
    {it.texel_red, it.texel_green, it.texel_blue} = 48'({$urandom, $urandom});
    it.coord_y = y; it.coord_z = z;
    return it;
  endfunction

  // fill the low texels; every grid in use keeps width times height
  // within them, so no sample reads an unwritten texel
  task automatic fill_store();
    for (int a = 0; a < STORE_FILL; a++)
      send_word(load_word(a[15:0], a[15:0] == 0 ? 48'hFFFF_FFFF_FFFF :
                          a[15:0] == 1 ? 48'h0 : 48'({$urandom, $urandom})));
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return {$urandom_range(15) == 0 ? 16'hFFFF : 16'($urandom_range(600)), 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        send_word(load_word($urandom_range(1) ? 16'($urandom_range(STORE_FILL - 1))
                                              : 16'($urandom),
                            48'({$urandom, $urandom})));
      else
        send_word(sample_word(rand_coord(), rand_coord()));
    end
  endtask

  initial begin
    logic [31:0] cfg [6];
    int wcl;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // grid small enough for the filled texels
    reg_write(REG_WIDTH, 32'd32); reg_write(REG_HEIGHT, 32'd16);
    fill_store();
    settle();

    // directed: coordinate extremes, fractions, negatives
    send_word(sample_word(32'h0, 32'h0));
    send_word(sample_word(32'h0000_8000, 32'h0000_FFFF));
    send_word(sample_word(32'hFFFF_FFFF, 32'hFFFF_0000));
    send_word(sample_word(32'h8000_0000, 32'h7FFF_FFFF));
    send_word(sample_word(32'h7FFF_FFFF, 32'h8000_0000));
    send_word(sample_word(32'h00FE_C000, 32'h00FF_4000));
    send_word(sample_word(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(load_word(16'hFFFF, 48'hFFFF_FFFF_FFFF));
    send_word(load_word(16'h0000, 48'h0));
    send_word(sample_word(32'h0, 32'h0));
    send_word(sample_word(32'h00FE_8000, 32'h00FE_8000));
    settle();

    // extreme register settings, size clamping included
    reg_write(REG_WIDTH, 32'h1FF); reg_write(REG_HEIGHT, 32'h0);
    reg_write(REG_SCALE_Y, 32'h8000_0000); reg_write(REG_SCALE_Z, 32'h7FFF_FFFF);
    reg_write(REG_SHIFT_Y, 32'h7FFF_FFFF); reg_write(REG_SHIFT_Z, 32'h8000_0000);
    for (int i = 0; i < 8; i++) send_word(sample_word(rand_coord(), rand_coord()));
    settle();
    reg_write(REG_WIDTH, 32'd2); reg_write(REG_HEIGHT, 32'd257);
    reg_write(REG_SCALE_Y, 32'hFFFF_0000); reg_write(REG_SCALE_Z, 32'h0);
    reg_write(REG_SHIFT_Y, 32'h0); reg_write(REG_SHIFT_Z, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_word(sample_word(rand_coord(), rand_coord()));
    settle();

    // random phases, each with its own settings, two of them with idle gaps
    for (int ph = 0; ph < 5; ph++) begin
      idle_pct = (ph == 1) ? 78 : (ph == 3) ? 23 : 0;
      cfg[0] = $urandom_range(1) ? 32'h10000 : $urandom;
      cfg[1] = $urandom_range(1) ? {$urandom_range(3), 16'($urandom)} : $urandom;
      cfg[2] = $urandom; cfg[3] = $urandom;
      cfg[4] = ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(40);
      wcl = (cfg[4] < 2) ? 2 : (cfg[4] > MAX_WIDTH) ? MAX_WIDTH : int'(cfg[4]);
      cfg[5] = $urandom_range(STORE_FILL / wcl);
      for (int r = 0; r < 6; r++) reg_write(r[2:0], cfg[r]);
      random_phase(40);
      settle();
    end

    $display("covered %0d samples over extreme and random register settings",
             board.samples);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("wrapped_smoothstep_bilinear_sampler_core test passed");
    else
      $display("wrapped_smoothstep_bilinear_sampler_core test failed");
    $finish;
  end
endmodule

>>> filelist.f
hdl/wssb_pkg.sv
hdl/wssb_ram.sv
hdl/wssb_wrap.sv
hdl/wrapped_smoothstep_bilinear_sampler_core.sv
test/tb.sv
